// ----- sv/usd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usd_pkg
// Types, codes and the single-position decode function of the stream decoder.
// ----------------------------------------------------------------------------
package usd_pkg;

    localparam int UNIT_W  = 16;
    localparam int CP_W    = 21;
    localparam int CNT_W   = 3;
    localparam int ST_W    = 3;
    localparam int CIDX_W  = 2;
    localparam int QDEPTH  = 4;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] CFG_IDX_MODE   = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_IDX_STRICT = 2'd1;

    // Result status codes.
    localparam logic [ST_W-1:0] ST_OK    = 3'd0;
    localparam logic [ST_W-1:0] ST_ASCII = 3'd1;
    localparam logic [ST_W-1:0] ST_LEAD  = 3'd2;
    localparam logic [ST_W-1:0] ST_CONT  = 3'd3;
    localparam logic [ST_W-1:0] ST_TRUNC = 3'd4;

    // Up to four queued code units, entry 0 at the head.
    typedef logic [QDEPTH-1:0][UNIT_W-1:0] unit_q_t;

    // Outcome of decoding at the head of a queue.
    typedef struct packed {
        logic            hold;
        logic [2:0]      used;
        logic [CP_W-1:0] cp;
        logic [CNT_W-1:0] bc;
        logic [ST_W-1:0] st;
    } dec_res_t;

    function automatic logic ascii_ok(logic [UNIT_W-1:0] c, logic strict);
        logic ok;
        ok = !strict
            || (c >= 16'h0020 && c < 16'h007F)
            || c == 16'h0009 || c == 16'h000A || c == 16'h000D;
        return ok;
    endfunction

    function automatic logic is_cont(logic [7:0] b);
        return b[7:6] == 2'b10;
    endfunction

    // Decodes one result at the head of q, where avail units are valid.
    // An empty queue, or a sequence that is still short, reports hold.
    function automatic dec_res_t usd_decode(unit_q_t q, logic [2:0] avail, logic eot,
                                            logic mode, logic strict);
        dec_res_t    r;
        logic [7:0]  b0;
        logic [15:0] v0;
        logic [15:0] v1;
        logic [2:0]  need;
        logic        bad;
        r    = '0;
        b0   = q[0][7:0];
        v0   = q[0];
        v1   = q[1];
        need = 3'd2;
        bad  = 1'b0;
        if (avail == 3'd0) begin
            r.hold = 1'b1;
        end else if (!mode) begin
            if (b0 < 8'h80) begin
                r.used = 3'd1;
                if (ascii_ok({8'h00, b0}, strict)) begin
                    r.cp = {13'b0, b0};
                    r.bc = 3'd1;
                end else begin
                    r.st = ST_ASCII;
                end
            end else if (b0 < 8'hC0) begin
                r.used = 3'd1;
                r.st   = ST_LEAD;
            end else begin
                need = (b0 < 8'hE0) ? 3'd2 : (b0 < 8'hF0) ? 3'd3 : 3'd4;
                for (int k = 1; k < QDEPTH; k++) begin
                    if (3'(k) < need && 3'(k) < avail && !is_cont(q[k][7:0])) begin
                        bad = 1'b1;
                    end
                end
                if (bad) begin
                    r.used = 3'd1;
                    r.st   = ST_CONT;
                end else if (avail < need) begin
                    if (eot) begin
                        r.used = 3'd1;
                        r.st   = ST_TRUNC;
                    end else begin
                        r.hold = 1'b1;
                    end
                end else begin
                    r.used = need;
                    r.bc   = need;
                    if (need == 3'd2) begin
                        r.cp = {10'b0, b0[4:0], q[1][5:0]};
                    end else if (need == 3'd3) begin
                        r.cp = {5'b0, b0[3:0], q[1][5:0], q[2][5:0]};
                    end else begin
                        r.cp = {b0[2:0], q[1][5:0], q[2][5:0], q[3][5:0]};
                    end
                end
            end
        end else begin
            if (v0 < 16'hD800 || v0 >= 16'hE000) begin
                r.used = 3'd1;
                if (v0 < 16'h0080 && !ascii_ok(v0, strict)) begin
                    r.st = ST_ASCII;
                end else begin
                    r.cp = {5'b0, v0};
                    r.bc = 3'd2;
                end
            end else if (v0 >= 16'hDC00) begin
                r.used = 3'd1;
                r.st   = ST_LEAD;
            end else if (avail < 3'd2) begin
                if (eot) begin
                    r.used = 3'd1;
                    r.st   = ST_TRUNC;
                end else begin
                    r.hold = 1'b1;
                end
            end else if (v1 < 16'hDC00 || v1 >= 16'hE000) begin
                r.used = 3'd1;
                r.st   = ST_CONT;
            end else begin
                // The surrogate offset is added, not merged into the upper bits.
                r.used = 3'd2;
                r.bc   = 3'd4;
                r.cp   = CP_W'({v0[9:0], v1[9:0]}) + 21'h10000;
            end
        end
        return r;
    endfunction

endpackage

// ----- sv/unicode_stream_decoder_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unicode_stream_decoder_top
// UTF-8 / UTF-16 stream decoder with error reporting and one-unit resync.
// ----------------------------------------------------------------------------
// Usage:
// One code unit arrives per word on the input channel (unit, end_of_text).
// Each accepted word joins a small queue of up to four units: the units held
// from earlier words plus the new one. Every cycle the decoder takes one result
// from the head of that queue and loads it into the output register, so a word
// yields zero to four result words; last_of_run marks the final one. A word
// that only extends a pending sequence yields no result.
// The queue registers an accepted word, then the output register its first
// result. Throughput is one word per cycle while each word yields at most one
// result and the receiver does not stall; a word with several results holds
// the decode stage while the single decode position at the queue head gives them
// out. The next word is taken in the cycle that delivers a word's last result.
// When the receiver stalls, the output register holds its word and the queue
// holds its units; no result is lost. At reset the queue is empty, the mode is
// UTF-8 and strict ascii checking is on. The configuration channel is always
// ready; writing the mode register drops every held unit.
// ----------------------------------------------------------------------------
module unicode_stream_decoder_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [usd_pkg::CIDX_W-1:0]   cfg_index,
    input  logic                         cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [usd_pkg::UNIT_W-1:0]   unit,
    input  logic                         end_of_text,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [usd_pkg::CP_W-1:0]     code_point,
    output logic [usd_pkg::CNT_W-1:0]    byte_count,
    output logic [usd_pkg::ST_W-1:0]     status,
    output logic                         last_of_run
);
    import usd_pkg::*;

    // Configuration registers.
    logic mode_reg, mode_next;
    logic strict_reg, strict_next;

    // Unit queue: held units, then the newest unit while a word is in work.
    unit_q_t    q_reg, q_next;
    logic [2:0] n_reg, n_next;
    logic       eot_reg, eot_next;
    // Set while the queue holds a word whose results are not all produced.
    logic       busy_reg, busy_next;

    // Output register.
    logic             ov_reg, ov_next;
    logic [CP_W-1:0]  cp_reg, cp_next;
    logic [CNT_W-1:0] bc_reg, bc_next;
    logic [ST_W-1:0]  st_reg, st_next;
    logic             last_reg, last_next;

    dec_res_t         dec_head;
    dec_res_t         dec_after;
    unit_q_t          q_shift;
    unit_q_t          q_app;
    logic [2:0]       rem;
    logic             out_free;
    logic             emit;
    logic             last_now;
    logic             finishing;
    logic             in_acc;
    logic             cfg_acc;
    logic [2:0]       slot;
    logic [UNIT_W-1:0] unit_in;

    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid && cfg_ready;

    // In UTF-8 mode only the low byte of a unit counts.
    assign unit_in = mode_reg ? unit : {8'h00, unit[7:0]};

    // Decode at the head, then look one result ahead to know whether this
    // result ends the run of the current word.
    assign dec_head  = usd_decode(q_reg, n_reg, eot_reg, mode_reg, strict_reg);
    assign rem       = n_reg - dec_head.used;
    assign q_shift   = q_reg >> {dec_head.used, 4'b0000};
    assign dec_after = usd_decode(q_shift, rem, eot_reg, mode_reg, strict_reg);
    assign last_now  = dec_after.hold;

    assign out_free  = !ov_reg || out_ready;
    assign emit      = busy_reg && !dec_head.hold && out_free;
    // A head that holds ends the word without any result.
    assign finishing = busy_reg && (dec_head.hold || (out_free && last_now));
    assign in_ready  = !busy_reg || finishing;
    assign in_acc    = in_valid && in_ready;

    // The new unit lands right behind what stays in the queue.
    assign slot = busy_reg ? rem : n_reg;

    always_comb
    begin
        q_app              = busy_reg ? q_shift : q_reg;
        q_app[slot[1:0]]   = unit_in;
    end

    always_comb
    begin
        mode_next   = mode_reg;
        strict_next = strict_reg;
        q_next      = q_reg;
        n_next      = n_reg;
        eot_next    = eot_reg;
        busy_next   = busy_reg;

        if (emit || finishing) begin
            q_next    = q_shift;
            n_next    = rem;
            busy_next = !finishing;
        end
        if (in_acc) begin
            q_next    = q_app;
            n_next    = slot + 3'd1;
            eot_next  = end_of_text;
            busy_next = 1'b1;
        end

        if (cfg_acc) begin
            case (cfg_index)
                CFG_IDX_MODE:
                begin
                    mode_next = cfg_data;
                    n_next    = 3'd0;
                end
                CFG_IDX_STRICT:
                begin
                    strict_next = cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        ov_next   = ov_reg && !out_ready;
        cp_next   = cp_reg;
        bc_next   = bc_reg;
        st_next   = st_reg;
        last_next = last_reg;
        if (emit) begin
            ov_next   = 1'b1;
            cp_next   = dec_head.cp;
            bc_next   = dec_head.bc;
            st_next   = dec_head.st;
            last_next = last_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg   <= 1'b0;
            strict_reg <= 1'b1;
            n_reg      <= 3'd0;
            eot_reg    <= 1'b0;
            busy_reg   <= 1'b0;
            ov_reg     <= 1'b0;
        end else begin
            mode_reg   <= mode_next;
            strict_reg <= strict_next;
            n_reg      <= n_next;
            eot_reg    <= eot_next;
            busy_reg   <= busy_next;
            ov_reg     <= ov_next;
        end
    end

    // Payload registers need no reset; n_reg and ov_reg qualify them.
    always_ff @(posedge clk)
    begin
        q_reg    <= q_next;
        cp_reg   <= cp_next;
        bc_reg   <= bc_next;
        st_reg   <= st_next;
        last_reg <= last_next;
    end

    assign out_valid   = ov_reg;
    assign code_point  = cp_reg;
    assign byte_count  = bc_reg;
    assign status      = st_reg;
    assign last_of_run = last_reg;

    // Between words the queue only holds an incomplete sequence.
    a_held_fits: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> n_reg <= 3'd3)
        else $error("held units exceed three");

    // Error results carry neither a value nor a byte count.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (code_point == '0 && byte_count == '0))
        else $error("error result with nonzero payload");

    // A result blocked by a stalled receiver leaves the queue untouched.
    a_stall_keeps_q: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !dec_head.hold && !out_free && !cfg_acc)
            |=> ($stable(n_reg) && $stable(q_reg)))
        else $error("queue changed while the output stalled");

endmodule

// ----- tb/decode_model_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decode_model_pkg
// Predicted code points and result checking for the unicode stream decoder.
// ----------------------------------------------------------------------------
package decode_model_pkg;

    import usd_pkg::*;

    // One result word as the decoder should deliver it.
    typedef struct packed {
        logic [CP_W-1:0]  cp;
        logic [CNT_W-1:0] bc;
        logic [ST_W-1:0]  st;
        logic             last;
    } point_t;

    // One input word waiting to be sent.
    typedef struct packed {
        logic [UNIT_W-1:0] code_unit;
        logic              eot;
    } unit_word_t;

    class utf_decode_model;

        logic              utf16_on;
        logic              strict_on;
        logic [UNIT_W-1:0] lead_unit;
        logic [7:0]        cont_byte [2];
        int                held;
        logic [UNIT_W-1:0] window [QDEPTH];
        point_t            burst [$];
        point_t            due_points [$];
        int                errors;

        function new();
            utf16_on     = 1'b0;
            strict_on    = 1'b1;
            lead_unit    = '0;
            cont_byte[0] = '0;
            cont_byte[1] = '0;
            held         = 0;
            errors       = 0;
        endfunction

        function void apply_reg(logic [CIDX_W-1:0] idx, logic data);
            if (idx == CFG_IDX_MODE) begin
                utf16_on     = data;
                held         = 0;
                lead_unit    = '0;
                cont_byte[0] = '0;
                cont_byte[1] = '0;
            end else if (idx == CFG_IDX_STRICT) begin
                strict_on = data;
            end
        endfunction

        // Tab, line feed, carriage return and the printable range pass.
        function bit ascii_pass(logic [UNIT_W-1:0] c);
            return !strict_on || (c >= 16'h0020 && c < 16'h007F)
                || c == 16'h0009 || c == 16'h000A || c == 16'h000D;
        endfunction

        function void add_point(logic [CP_W-1:0] cp, logic [CNT_W-1:0] bc,
                                logic [ST_W-1:0] st);
            point_t pt;
            pt.cp   = cp;
            pt.bc   = bc;
            pt.st   = st;
            pt.last = 1'b0;
            burst.push_back(pt);
        endfunction

        // Returns the units consumed at position p, or 0 to keep them held.
        function int decode8_at(int p, int n, logic eot);
            logic [7:0]      b;
            int              need;
            logic [CP_W-1:0] cp;
            b = window[p][7:0];
            if (b < 8'h80) begin
                if (ascii_pass({8'h00, b})) begin
                    add_point(CP_W'(b), 3'd1, ST_OK);
                end else begin
                    add_point('0, '0, ST_ASCII);
                end
                return 1;
            end
            if (b < 8'hC0) begin
                add_point('0, '0, ST_LEAD);
                return 1;
            end
            need = (b < 8'hE0) ? 2 : (b < 8'hF0) ? 3 : 4;
            for (int k = 1; k < need && k < n - p; k++) begin
                if (window[p + k][7:6] != 2'b10) begin
                    add_point('0, '0, ST_CONT);
                    return 1;
                end
            end
            if (n - p < need) begin
                if (eot) begin
                    add_point('0, '0, ST_TRUNC);
                    return 1;
                end
                return 0;
            end
            case (need)
                2: cp = CP_W'({b[4:0], window[p + 1][5:0]});
                3: cp = CP_W'({b[3:0], window[p + 1][5:0], window[p + 2][5:0]});
                default: cp = {b[2:0], window[p + 1][5:0], window[p + 2][5:0],
                               window[p + 3][5:0]};
            endcase
            add_point(cp, CNT_W'(need), ST_OK);
            return need;
        endfunction

        function int decode16_at(int p, int n, logic eot);
            logic [UNIT_W-1:0] v0;
            logic [UNIT_W-1:0] v1;
            logic [CP_W-1:0]   cp;
            v0 = window[p];
            if (v0 < 16'hD800 || v0 >= 16'hE000) begin
                if (v0 < 16'h0080 && !ascii_pass(v0)) begin
                    add_point('0, '0, ST_ASCII);
                end else begin
                    add_point(CP_W'(v0), 3'd2, ST_OK);
                end
                return 1;
            end
            if (v0 >= 16'hDC00) begin
                add_point('0, '0, ST_LEAD);
                return 1;
            end
            if (n - p < 2) begin
                if (eot) begin
                    add_point('0, '0, ST_TRUNC);
                    return 1;
                end
                return 0;
            end
            v1 = window[p + 1];
            if (v1 < 16'hDC00 || v1 >= 16'hE000) begin
                add_point('0, '0, ST_CONT);
                return 1;
            end
            cp = CP_W'(v0 - 16'hD800) * 21'h400 + CP_W'(v1 - 16'hDC00) + 21'h10000;
            add_point(cp, 3'd4, ST_OK);
            return 2;
        endfunction

        // An accepted input word: rebuild the unit window, decode it from the
        // head, and keep whatever is still incomplete for the next word.
        function void take_unit(logic [UNIT_W-1:0] u, logic eot);
            int     n;
            int     p;
            int     used;
            point_t tail;
            burst.delete();
            n = 0;
            p = 0;
            if (utf16_on && held > 1) begin
                held = 1;
            end
            if (held > 0) begin
                window[n] = utf16_on ? lead_unit : {8'h00, lead_unit[7:0]};
                n++;
            end
            for (int k = 1; k < held; k++) begin
                window[n] = {8'h00, cont_byte[k - 1]};
                n++;
            end
            window[n] = utf16_on ? u : {8'h00, u[7:0]};
            n++;
            while (p < n) begin
                used = utf16_on ? decode16_at(p, n, eot) : decode8_at(p, n, eot);
                if (used == 0) begin
                    break;
                end
                p += used;
            end
            held         = n - p;
            lead_unit    = '0;
            cont_byte[0] = '0;
            cont_byte[1] = '0;
            if (held > 0) begin
                lead_unit = window[p];
            end
            for (int k = 1; k < held; k++) begin
                cont_byte[k - 1] = window[p + k][7:0];
            end
            if (burst.size() > 0) begin
                tail      = burst.pop_back();
                tail.last = 1'b1;
                burst.push_back(tail);
            end
            while (burst.size() > 0) begin
                due_points.push_back(burst.pop_front());
            end
        endfunction

        function void match_point(logic [CP_W-1:0] cp, logic [CNT_W-1:0] bc,
                                  logic [ST_W-1:0] st, logic last);
            point_t want;
            if (due_points.size() == 0) begin
                $error("result word with nothing expected: code_point=%0h status=%0d",
                       cp, st);
                errors++;
                return;
            end
            want = due_points.pop_front();
            if (cp !== want.cp) begin
                $error("code_point: expected %0h, got %0h", want.cp, cp);
                errors++;
            end
            if (bc !== want.bc) begin
                $error("byte_count: expected %0d, got %0d", want.bc, bc);
                errors++;
            end
            if (st !== want.st) begin
                $error("status: expected %0d, got %0d", want.st, st);
                errors++;
            end
            if (last !== want.last) begin
                $error("last_of_run: expected %0b, got %0b", want.last, last);
                errors++;
            end
        endfunction

    endclass

endpackage

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks unicode_stream_decoder_top against a cycle-free prediction of its
// decoded code points in both UTF-8 and UTF-16 modes, under random idling on
// the input and output channels and several register settings.
// ----------------------------------------------------------------------------
module testbench;

    import usd_pkg::*;
    import decode_model_pkg::*;

    localparam int     HALF_PERIOD   = 5;
    localparam int     RESET_CYCLES  = 8;
    // After the last expected result, these cycles cover a word that produced
    // nothing but is still in the pipe.
    localparam int     SETTLE_CYCLES = 6;
    localparam longint LIMIT_NS      = 2_000_000;
    localparam int     IDLE_PERCENT  = 20;

    // Register indexes with no register behind them; writes must be ignored.
    localparam logic [CIDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cfg_valid   = 1'b0;
    logic               cfg_ready;
    logic [CIDX_W-1:0]  cfg_index   = '0;
    logic               cfg_data    = 1'b0;
    logic               in_valid    = 1'b0;
    logic               in_ready;
    logic [UNIT_W-1:0]  unit        = '0;
    logic               end_of_text = 1'b0;
    logic               out_valid;
    logic               out_ready   = 1'b0;
    logic [CP_W-1:0]    code_point;
    logic [CNT_W-1:0]   byte_count;
    logic [ST_W-1:0]    status;
    logic               last_of_run;

    // Holds the expected code points and the decoder state we predict.
    utf_decode_model decode_model = new();

    // Input words queued for the next send.
    unit_word_t plan [$];

    // While set, neither side idles: a long stretch of full-rate traffic.
    logic calm = 1'b0;

    always #HALF_PERIOD clk = ~clk;

    unicode_stream_decoder_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .unit        (unit),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .code_point  (code_point),
        .byte_count  (byte_count),
        .status      (status),
        .last_of_run (last_of_run)
    );

    // All three channels are observed at the rising edge. Inputs only move at
    // the falling edge, so the values seen here are the ones the block used.
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                decode_model.apply_reg(cfg_index, cfg_data);
            end
            if (in_valid && in_ready) begin
                decode_model.take_unit(unit, end_of_text);
            end
            if (out_valid && out_ready) begin
                decode_model.match_point(code_point, byte_count, status, last_of_run);
            end
        end
    end

    // The receiver stalls at random, IDLE_PERCENT of the time, except in the calm stretch.
    always @(negedge clk) begin
        if (calm) begin
            out_ready <= 1'b1;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    function automatic void add_word(logic [UNIT_W-1:0] u, logic eot);
        unit_word_t w;
        w.code_unit = u;
        w.eot       = eot;
        plan.push_back(w);
    endfunction

    // Random text ends now and then, often in the middle of a sequence,
    // which is how truncation gets exercised.
    function automatic void add_text(logic [UNIT_W-1:0] u);
        add_word(u, $urandom_range(0, 11) == 0);
    endfunction

    // One UTF-8 sequence. Most are well formed with random content; the rest
    // are broken sequences and raw noise. The upper byte of each word is
    // random because the decoder must ignore it in this mode.
    function automatic void gen_utf8();
        int         kind;
        int         need;
        int         keep;
        logic [7:0] b;
        kind = $urandom_range(0, 99);
        if (kind < 25) begin
            b = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 31))
                                            : 8'($urandom_range(32, 127));
            add_text({8'($urandom), b});
        end else if (kind < 85) begin
            need = (kind < 45) ? 2 : (kind < 65) ? 3 : 4;
            b = (need == 2) ? (8'hC0 | 8'($urandom_range(0, 31)))
              : (need == 3) ? (8'hE0 | 8'($urandom_range(0, 15)))
                            : (8'hF0 | 8'($urandom_range(0, 15)));
            add_text({8'($urandom), b});
            for (int k = 1; k < need; k++) begin
                add_text({8'($urandom), 8'h80 | 8'($urandom_range(0, 63))});
            end
        end else if (kind < 93) begin
            // A lead cut short by a byte that cannot continue it.
            need = $urandom_range(2, 4);
            keep = $urandom_range(0, need - 2);
            b = (need == 2) ? 8'hC5 : (need == 3) ? 8'hE3 : 8'hF1;
            add_text({8'($urandom), b});
            for (int k = 0; k < keep; k++) begin
                add_text({8'($urandom), 8'h80 | 8'($urandom_range(0, 63))});
            end
            b = $urandom_range(0, 1) ? 8'($urandom_range(0, 127))
                                     : 8'($urandom_range(192, 255));
            add_text({8'($urandom), b});
        end else begin
            add_text(16'($urandom));
        end
    endfunction

    // One UTF-16 item: plain units, surrogate pairs, lone surrogates of both
    // kinds and raw noise.
    function automatic void gen_utf16();
        int                kind;
        logic [UNIT_W-1:0] plain;
        kind  = $urandom_range(0, 99);
        plain = 16'($urandom);
        if (plain[15:11] == 5'b11011) begin
            plain[15] = 1'b0;
        end
        if (kind < 35) begin
            if ($urandom_range(0, 4) == 0) begin
                plain = 16'($urandom_range(0, 127));
            end
            add_text(plain);
        end else if (kind < 75) begin
            add_text(16'hD800 | 16'($urandom_range(0, 1023)));
            add_text(16'hDC00 | 16'($urandom_range(0, 1023)));
        end else if (kind < 83) begin
            add_text(16'hDC00 | 16'($urandom_range(0, 1023)));
        end else if (kind < 91) begin
            add_text(16'hD800 | 16'($urandom_range(0, 1023)));
            add_text(plain);
        end else begin
            add_text(16'($urandom));
        end
    endfunction

    // Sends every queued word. Valid is raised at a falling edge and held,
    // payload unchanged, until the block takes the word at a rising edge.
    task automatic send_plan();
        unit_word_t w;
        while (plan.size() > 0) begin
            w = plan.pop_front();
            @(negedge clk);
            if (!calm) begin
                while ($urandom_range(0, 99) < IDLE_PERCENT) begin
                    in_valid <= 1'b0;
                    @(negedge clk);
                end
            end
            in_valid    <= 1'b1;
            unit        <= w.code_unit;
            end_of_text <= w.eot;
            do begin
                @(posedge clk);
            end while (!in_ready);
        end
    endtask

    task automatic cfg_write(logic [CIDX_W-1:0] idx, logic data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do begin
            @(posedge clk);
        end while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every predicted word has come back, then lets the pipe
    // empty of words that produced nothing, so the block is idle.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (decode_model.due_points.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // UTF-8 with strict ascii. The write to a missing register must
        // leave everything as it was.
        cfg_write(CFG_IDX_MODE, 1'b0);
        cfg_write(CFG_IDX_STRICT, 1'b1);
        cfg_write(CFG_IDX_SPARE_HI, 1'b1);

        // Printable, tab, line feed, carriage return, then controls that
        // strict mode rejects.
        add_word(16'h0041, 1'b0);
        add_word(16'h0009, 1'b0);
        add_word(16'h000A, 1'b0);
        add_word(16'h000D, 1'b0);
        add_word(16'h0000, 1'b0);
        add_word(16'h007F, 1'b0);
        // A stray continuation byte where a lead belongs.
        add_word(16'h0080, 1'b0);
        // Two-, three- and four-byte forms; 0xFF still counts as a 4-byte lead.
        add_word(16'h00C3, 1'b0);
        add_word(16'h00A9, 1'b0);
        add_word(16'h00EF, 1'b0);
        add_word(16'h00BF, 1'b0);
        add_word(16'h00BF, 1'b0);
        add_word(16'h00FF, 1'b0);
        add_word(16'h00BF, 1'b0);
        add_word(16'h00BF, 1'b0);
        add_word(16'h00BF, 1'b0);
        // A lead followed by ascii: bad continuation, then the ascii replays.
        add_word(16'h00C3, 1'b0);
        add_word(16'h0041, 1'b0);
        // Three held bytes broken by a control: four results from one word.
        add_word(16'h00F0, 1'b0);
        add_word(16'h0080, 1'b0);
        add_word(16'h0080, 1'b0);
        add_word(16'h007F, 1'b0);
        // Text that ends inside a sequence.
        add_word(16'h00E2, 1'b0);
        add_word(16'h0082, 1'b1);
        // Upper byte set: ignored in UTF-8 mode.
        add_word(16'hFF41, 1'b0);
        send_plan();
        while (plan.size() < 20) gen_utf8();
        send_plan();
        settle();

        // UTF-8 with every ascii unit allowed.
        cfg_write(CFG_IDX_STRICT, 1'b0);
        cfg_write(CFG_IDX_SPARE_LO, 1'b0);
        add_word(16'h0000, 1'b0);
        add_word(16'h001B, 1'b0);
        add_word(16'h007F, 1'b0);
        send_plan();
        while (plan.size() < 12) gen_utf8();
        // Leave a lead pending; the mode write below has to drop it.
        add_word(16'h00E2, 1'b0);
        send_plan();
        settle();

        // UTF-16 with strict ascii.
        cfg_write(CFG_IDX_MODE, 1'b1);
        cfg_write(CFG_IDX_STRICT, 1'b1);
        add_word(16'h0041, 1'b0);
        add_word(16'h0001, 1'b0);
        add_word(16'hD7FF, 1'b0);
        add_word(16'hE000, 1'b0);
        add_word(16'hFFFF, 1'b0);
        // Surrogate pairs at both ends of the range and in the middle.
        add_word(16'hD83D, 1'b0);
        add_word(16'hDE00, 1'b0);
        add_word(16'hDBFF, 1'b0);
        add_word(16'hDFFF, 1'b0);
        add_word(16'hD800, 1'b0);
        add_word(16'hDC00, 1'b0);
        // A low surrogate on its own.
        add_word(16'hDC00, 1'b0);
        // A high surrogate followed by a plain unit, then by another high.
        add_word(16'hD800, 1'b0);
        add_word(16'h0041, 1'b0);
        add_word(16'hD800, 1'b0);
        add_word(16'hD801, 1'b0);
        add_word(16'hDC00, 1'b0);
        // Text that ends right after a high surrogate.
        add_word(16'hDBFF, 1'b1);
        send_plan();
        // Full-rate stretch on both sides.
        calm = 1'b1;
        while (plan.size() < 20) gen_utf16();
        send_plan();
        calm = 1'b0;
        settle();

        // UTF-16 with every ascii unit allowed.
        cfg_write(CFG_IDX_STRICT, 1'b0);
        while (plan.size() < 12) gen_utf16();
        send_plan();
        settle();

        // Back to UTF-8 at the reset settings.
        cfg_write(CFG_IDX_MODE, 1'b0);
        cfg_write(CFG_IDX_STRICT, 1'b1);
        while (plan.size() < 15) gen_utf8();
        send_plan();
        settle();

        if (decode_model.errors == 0) begin
            $display("unicode_stream_decoder_top verification clean");
        end else begin
            $display("unicode_stream_decoder_top verification failed");
        end
        $finish;
    end

    // A hung handshake or a missing result ends the run here.
    initial begin
        #(LIMIT_NS);
        $display("unicode_stream_decoder_top verification failed");
        $finish;
    end

endmodule
